// ----- rtl/bse_pkg.sv -----
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, constants and helpers for the bitonic sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int MAX_ELEMENTS = 64;
    // Network size: store depth rounded up to a power of two.
    localparam int IDX_W    = $clog2(MAX_ELEMENTS);
    localparam int NET_SIZE = 1 << IDX_W;
    localparam int PAIR_W   = IDX_W - 1;
    localparam int BANK_AW  = IDX_W - 1;
    localparam int CNT_W    = IDX_W + 1;
    localparam int LOG_W    = $clog2(IDX_W + 1);
    localparam int DATA_W   = 32;
    localparam int CMP_W    = 10;

    localparam logic signed [DATA_W-1:0] PAD_VALUE = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_res;
        logic [CMP_W-1:0]         comparisons;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_en;
        logic             wr_pad;
        logic [IDX_W-1:0] wr_idx;
        logic             rd_cmp;
        logic [IDX_W-1:0] rd_a_idx;
        logic [IDX_W-1:0] rd_b_idx;
        logic             asc;
        logic             out_load;
        logic             out_last;
        logic [CMP_W-1:0] cmp_count;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Smallest s with 2**s >= n
    function automatic logic [LOG_W-1:0] f_ceil_log2(input logic [CNT_W-1:0] n);
        logic [LOG_W-1:0] r;
        r = LOG_W'(IDX_W);
        for (int s = IDX_W; s >= 0; s--) begin
            if ((32'd1 << s) >= 32'(n)) begin
                r = LOG_W'(s);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/bse_ram.sv -----
// ----------------------------------------------------------------------------
// bse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bse_datapath.sv -----
// ----------------------------------------------------------------------------
// bse_datapath
// Two parity banks holding the set, the compare-exchange unit and the
// result register.
// ----------------------------------------------------------------------------
module bse_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bse_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [bse_pkg::DATA_W-1:0] i_value,
    input  logic                              i_out_ready,
    output bse_pkg::t_dp_status               o_status,
    output logic                              o_out_valid,
    output bse_pkg::t_out                     o_out_data
);

    // Element x lives in bank ^x at row x[IDX_W-1:1]; a compare pair
    // differs in one bit, so its two elements always sit in different banks.
    logic                            w_a_bank;
    logic [bse_pkg::BANK_AW-1:0]     w_raddr0, w_raddr1;
    logic                            w_we0, w_we1;
    logic [bse_pkg::BANK_AW-1:0]     w_waddr0, w_waddr1;
    logic [bse_pkg::DATA_W-1:0]      w_wdata0, w_wdata1, w_wr_val;
    logic [bse_pkg::DATA_W-1:0]      w_q0, w_q1;
    logic signed [bse_pkg::DATA_W-1:0] w_x, w_y, w_new_a, w_new_b;
    logic                            w_swap;

    logic                            r_wb;
    logic                            r_a_bank;
    logic                            r_asc;
    logic [bse_pkg::BANK_AW-1:0]     r_a_row, r_b_row;
    logic                            r_out_valid;
    bse_pkg::t_out                   r_out;

    assign w_a_bank = ^i_cmd.rd_a_idx;
    assign w_raddr0 = w_a_bank ? i_cmd.rd_b_idx[bse_pkg::IDX_W-1:1]
                               : i_cmd.rd_a_idx[bse_pkg::IDX_W-1:1];
    assign w_raddr1 = w_a_bank ? i_cmd.rd_a_idx[bse_pkg::IDX_W-1:1]
                               : i_cmd.rd_b_idx[bse_pkg::IDX_W-1:1];

    // Read data of the pair issued last cycle
    assign w_x    = r_a_bank ? w_q1 : w_q0;
    assign w_y    = r_a_bank ? w_q0 : w_q1;
    assign w_swap = r_asc ? (w_x > w_y) : (w_x < w_y);
    assign w_new_a = w_swap ? w_y : w_x;
    assign w_new_b = w_swap ? w_x : w_y;

    assign w_wr_val = i_cmd.wr_pad ? bse_pkg::PAD_VALUE : i_value;

    always_comb begin
        if (r_wb) begin
            w_we0    = 1'b1;
            w_we1    = 1'b1;
            w_waddr0 = r_a_bank ? r_b_row : r_a_row;
            w_waddr1 = r_a_bank ? r_a_row : r_b_row;
            w_wdata0 = r_a_bank ? w_new_b : w_new_a;
            w_wdata1 = r_a_bank ? w_new_a : w_new_b;
        end else begin
            w_we0    = i_cmd.wr_en & ~(^i_cmd.wr_idx);
            w_we1    = i_cmd.wr_en & (^i_cmd.wr_idx);
            w_waddr0 = i_cmd.wr_idx[bse_pkg::IDX_W-1:1];
            w_waddr1 = i_cmd.wr_idx[bse_pkg::IDX_W-1:1];
            w_wdata0 = w_wr_val;
            w_wdata1 = w_wr_val;
        end
    end

    bse_ram #(
        .WIDTH (bse_pkg::DATA_W),
        .DEPTH (bse_pkg::NET_SIZE / 2)
    ) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr0),
        .i_wdata (w_wdata0),
        .i_raddr (w_raddr0),
        .o_rdata (w_q0)
    );

    bse_ram #(
        .WIDTH (bse_pkg::DATA_W),
        .DEPTH (bse_pkg::NET_SIZE / 2)
    ) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_waddr1),
        .i_wdata (w_wdata1),
        .i_raddr (w_raddr1),
        .o_rdata (w_q1)
    );

    always_ff @(posedge i_clk) begin
        r_a_bank <= w_a_bank;
        r_asc    <= i_cmd.asc;
        r_a_row  <= i_cmd.rd_a_idx[bse_pkg::IDX_W-1:1];
        r_b_row  <= i_cmd.rd_b_idx[bse_pkg::IDX_W-1:1];
        if (i_cmd.out_load) begin
            r_out.sorted_value <= w_x;
            r_out.last_res     <= i_cmd.out_last;
            r_out.comparisons  <= i_cmd.cmp_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wb <= i_cmd.rd_cmp;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

// ----- rtl/bse_ctrl.sv -----
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer: loads the set, pads it, walks the bitonic network one
// compare-exchange per cycle within each stage and drives the result readout.
// ----------------------------------------------------------------------------
module bse_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    input  bse_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output bse_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_LOAD    = 6'b000001,
        S_PAD     = 6'b000010,
        S_SORT    = 6'b000100,
        S_DRAIN   = 6'b001000,
        S_EMIT_RD = 6'b010000,
        S_EMIT_LD = 6'b100000
    } t_state;

    t_state                        r_state, n_state;
    logic [bse_pkg::CNT_W-1:0]     r_count, n_count;
    logic [bse_pkg::CNT_W-1:0]     r_n, n_n;
    logic [bse_pkg::CNT_W-1:0]     r_pos, n_pos;
    logic [bse_pkg::LOG_W-1:0]     r_plog, n_plog;
    logic [bse_pkg::LOG_W-1:0]     r_kk, n_kk;
    logic [bse_pkg::LOG_W-1:0]     r_jj, n_jj;
    logic [bse_pkg::PAIR_W-1:0]    r_m, n_m;
    logic [bse_pkg::CMP_W-1:0]     r_cmp, n_cmp;

    logic [bse_pkg::CNT_W-1:0]     w_p, w_half, w_n_new;
    logic [bse_pkg::IDX_W-1:0]     w_m_ext, w_bit, w_i, w_l;
    logic                          w_asc, w_room;

    assign w_p    = bse_pkg::CNT_W'(1) << r_plog;
    assign w_half = w_p >> 1;

    // Pair m of the stage with distance 2**jj: insert a zero at bit jj.
    assign w_m_ext = bse_pkg::IDX_W'(r_m);
    assign w_bit   = bse_pkg::IDX_W'(1) << r_jj;
    assign w_i     = ((w_m_ext >> r_jj) << (r_jj + bse_pkg::LOG_W'(1)))
                   | (w_m_ext & (w_bit - bse_pkg::IDX_W'(1)));
    assign w_l     = w_i | w_bit;
    assign w_asc   = ((w_i >> r_kk) & bse_pkg::IDX_W'(1)) == '0;

    assign w_room  = r_count < bse_pkg::CNT_W'(bse_pkg::MAX_ELEMENTS);
    assign w_n_new = w_room ? r_count + bse_pkg::CNT_W'(1) : r_count;

    assign o_in_ready = (r_state == S_LOAD);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_n     = r_n;
        n_pos   = r_pos;
        n_plog  = r_plog;
        n_kk    = r_kk;
        n_jj    = r_jj;
        n_m     = r_m;
        n_cmp   = r_cmp;
        o_cmd   = '0;
        o_cmd.cmp_count = r_cmp;

        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (w_room) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_idx = r_count[bse_pkg::IDX_W-1:0];
                        n_count      = w_n_new;
                    end
                    if (i_in_last) begin
                        n_n     = w_n_new;
                        n_plog  = bse_pkg::f_ceil_log2(w_n_new);
                        n_pos   = w_n_new;
                        n_cmp   = '0;
                        n_count = '0;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_pos < w_p) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_pad = 1'b1;
                    o_cmd.wr_idx = r_pos[bse_pkg::IDX_W-1:0];
                    n_pos        = r_pos + bse_pkg::CNT_W'(1);
                end else if (r_plog == '0) begin
                    n_pos   = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_kk    = bse_pkg::LOG_W'(1);
                    n_jj    = '0;
                    n_m     = '0;
                    n_state = S_SORT;
                end
            end
            S_SORT: begin
                o_cmd.rd_cmp   = 1'b1;
                o_cmd.rd_a_idx = w_i;
                o_cmd.rd_b_idx = w_l;
                o_cmd.asc      = w_asc;
                n_cmp          = r_cmp + bse_pkg::CMP_W'(1);
                if (bse_pkg::CNT_W'(r_m) == w_half - bse_pkg::CNT_W'(1)) begin
                    n_m     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_m = r_m + bse_pkg::PAIR_W'(1);
                end
            end
            S_DRAIN: begin
                // last write-back of the stage lands this cycle
                if (r_jj != '0) begin
                    n_jj    = r_jj - bse_pkg::LOG_W'(1);
                    n_state = S_SORT;
                end else if (r_kk == r_plog) begin
                    n_pos   = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_kk    = r_kk + bse_pkg::LOG_W'(1);
                    n_jj    = r_kk;
                    n_state = S_SORT;
                end
            end
            S_EMIT_RD: begin
                o_cmd.rd_a_idx = r_pos[bse_pkg::IDX_W-1:0];
                o_cmd.rd_b_idx = r_pos[bse_pkg::IDX_W-1:0];
                if (i_status.out_free) begin
                    n_state = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = (r_pos + bse_pkg::CNT_W'(1) == r_n);
                n_pos          = r_pos + bse_pkg::CNT_W'(1);
                n_state        = o_cmd.out_last ? S_LOAD : S_EMIT_RD;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_n     <= '0;
            r_pos   <= '0;
            r_plog  <= '0;
            r_kk    <= '0;
            r_jj    <= '0;
            r_m     <= '0;
            r_cmp   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_n     <= n_n;
            r_pos   <= n_pos;
            r_plog  <= n_plog;
            r_kk    <= n_kk;
            r_jj    <= n_jj;
            r_m     <= n_m;
            r_cmp   <= n_cmp;
        end
    end

endmodule

// ----- rtl/bitonic_sort_engine.sv -----
// Loading writes each accepted input transaction into the store while there is
// room. After the transaction marked last, padding fills the set up to p, where p
// is n rounded up to a power of two; the network then runs log2(p)*(log2(p)+1)/2
// stages on a single compare-exchange unit; results leave one at a time, each
// loaded only when the result register is free. Reset is synchronous, active
// low, clears the control state and needs no clearing pass.
// ----------------------------------------------------------------------------
// bitonic_sort_engine
// Collects a set of signed 32-bit values, sorts it ascending with a bitonic
// network and streams the sorted set out with a comparison count.
// ----------------------------------------------------------------------------
module bitonic_sort_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input channel
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bse_pkg::t_in   i_in_data,
    // result channel
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bse_pkg::t_out  o_out_data
);

    // Command and status between sequencer and datapath
    bse_pkg::t_dp_cmd    w_cmd;
    bse_pkg::t_dp_status w_status;

    // The sequencer owns every counter: the store fill count, the network
    // position (block size, distance, pair) and the compare count. Each sort
    // cycle it issues one pair read; the datapath exchanges and writes back
    // the pair on the next cycle, and a drain cycle between stages keeps a
    // stage from reading values that are still being written back.
    bse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // The datapath keeps the set in two banks split by index parity so both
    // halves of a pair read and write in the same cycle. The result register
    // decouples the result channel: the last result of a set may wait there
    // while the next set already loads.
    bse_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (i_in_data.value),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A result is loaded only into an empty result register.
    a_load_into_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !o_out_valid)
        else $error("result register overwritten");

    // A compare pair always differs in exactly one index bit (one per bank).
    a_pair_banks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_cmp |-> $onehot(w_cmd.rd_a_idx ^ w_cmd.rd_b_idx))
        else $error("compare pair maps to one bank");

    // The transaction that closes a set stops loading until its last result is loaded.
    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last |=> !o_in_ready)
        else $error("input still accepted after last");

    // No load or pad write competes with a compare read.
    a_no_write_in_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_cmp |-> !w_cmd.wr_en && !$past(w_cmd.wr_en && !w_cmd.wr_pad))
        else $error("store write during network walk");

endmodule

// ----- tb/bse_sort_checker.sv -----
// ----------------------------------------------------------------------------
// bse_sort_checker
// Watches both channels of the sort engine, rebuilds every set from the
// accepted input transactions, predicts the sorted stream and the
// compare-exchange count, and compares each accepted result against it.
// ----------------------------------------------------------------------------
module bse_sort_checker
    import bse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    logic signed [DATA_W-1:0] set_vals [MAX_ELEMENTS];
    int   set_len  = 0;
    t_out sorted_queue [$];
    t_out got;
    t_out want;
    int   fail_cnt = 0;
    int   pend_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pend_cnt;

    // Pad the set to a power of two with the largest value, run the bitonic
    // network over it and queue the first set_len outputs.
    function automatic void predict_sorted_set();
        logic signed [DATA_W-1:0] keys [NET_SIZE];
        logic signed [DATA_W-1:0] tmp;
        int   width;
        int   span;
        int   stride;
        int   i;
        int   partner;
        int   n_cmp;
        bit   up;
        t_out res;
        width = 1;
        while (width < set_len) width *= 2;
        for (i = 0; i < NET_SIZE; i++) begin
            keys[i] = (i < set_len) ? set_vals[i] : PAD_VALUE;
        end
        n_cmp = 0;
        for (span = 2; span <= width; span *= 2) begin
            for (stride = span / 2; stride > 0; stride /= 2) begin
                for (i = 0; i < width; i++) begin
                    partner = i ^ stride;
                    if (partner > i) begin
                        up = ((i & span) == 0);
                        n_cmp++;
                        if (up ? (keys[i] > keys[partner]) : (keys[i] < keys[partner])) begin
                            tmp           = keys[i];
                            keys[i]       = keys[partner];
                            keys[partner] = tmp;
                        end
                    end
                end
            end
        end
        for (i = 0; i < set_len; i++) begin
            res.sorted_value = keys[i];
            res.last_res     = (i == set_len - 1);
            res.comparisons  = CMP_W'(n_cmp);
            sorted_queue.push_back(res);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_len = 0;
        end else begin
            // check results before taking new elements, so a result can never
            // consume an expectation queued at the same edge
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (sorted_queue.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("unexpected result: value %0d last %0b count %0d",
                                 got.sorted_value, got.last_res, got.comparisons);
                    end
                end else begin
                    want = sorted_queue.pop_front();
                    if (got.sorted_value !== want.sorted_value ||
                        got.last_res !== want.last_res ||
                        got.comparisons !== want.comparisons) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("mismatch: exp %0d/%0b/%0d got %0d/%0b/%0d",
                                     want.sorted_value, want.last_res, want.comparisons,
                                     got.sorted_value, got.last_res, got.comparisons);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                // drop elements beyond the store size
                if (set_len < MAX_ELEMENTS) begin
                    set_vals[set_len] = i_in_data.value;
                    set_len++;
                end
                if (i_in_data.last) begin
                    predict_sorted_set();
                    set_len = 0;
                end
            end
        end
        pend_cnt <= sorted_queue.size();
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives sets of signed values into the bitonic sort engine with random
// gaps and result stalls, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;
    import bse_pkg::*;

    // mixes of element values within one set
    typedef enum int {
        VAL_WIDE,
        VAL_NARROW,
        VAL_EDGE
    } t_val_mix;

    localparam int STORED_TARGET = 260;
    localparam int MAX_GAP       = 6;
    localparam int TAIL_CYCLES   = 40;
    localparam int LIMIT_CYCLES  = 400000;

    localparam logic signed [DATA_W-1:0] MIN_VALUE = 32'sh8000_0000;

    // Directed sets: single minimum, single maximum, a swapped pair, a set of
    // repeated extremes in which the maximum equals the padding value, a descending set.
    localparam int DIR_COUNT = 16;
    localparam logic signed [DATA_W-1:0] DIR_VALS [DIR_COUNT] = '{
        MIN_VALUE, PAD_VALUE,
        PAD_VALUE, MIN_VALUE,
        32'sd0, -32'sd1, PAD_VALUE, MIN_VALUE, PAD_VALUE, MIN_VALUE, 32'sd1,
        32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0
    };
    localparam bit DIR_LAST [DIR_COUNT] = '{
        1'b1, 1'b1,
        1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b1
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;
    int   fail_count;
    int   pending;

    bit   tx_quiet  = 1'b0;
    bit   rx_quiet  = 1'b0;
    int   rx_hold   = 0;
    int   rx_draw;

    always #6 clk = ~clk;

    bitonic_sort_engine u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    bse_sort_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: after every accepted result, hold ready low for a random
    // number of cycles. Now and then switch into a quiet stretch where ready
    // stays high.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_hold   <= 0;
            rx_quiet  <= 1'b0;
        end else if (out_valid && out_ready) begin
            if ($urandom_range(0, 15) == 0) begin
                rx_quiet <= !rx_quiet;
            end
            rx_draw = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            rx_hold   <= rx_draw;
            out_ready <= (rx_draw == 0);
        end else if (rx_hold != 0) begin
            rx_hold   <= rx_hold - 1;
            out_ready <= (rx_hold == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Offer one element: idle for a random gap first, unless in a quiet set,
    // then hold valid and the payload until the transaction is accepted.
    task automatic send_item(input logic signed [DATA_W-1:0] val, input logic lst);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{value: val, last: lst};
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and stall the sender until every predicted result is out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic signed [DATA_W-1:0] draw_value(input t_val_mix mix);
        logic signed [DATA_W-1:0] v;
        case (mix)
            VAL_NARROW: v = int'($urandom_range(0, 6)) - 3;
            VAL_EDGE: begin
                case ($urandom_range(0, 5))
                    0: v = MIN_VALUE;
                    1: v = PAD_VALUE;
                    2: v = 32'sd0;
                    3: v = -32'sd1;
                    4: v = MIN_VALUE + 32'sd1;
                    default: v = PAD_VALUE - 32'sd1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin
        int       stored;
        int       set_idx;
        int       set_size;
        int       i;
        t_val_mix mix;

        // hold reset, then release it once for good
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets
        for (i = 0; i < DIR_COUNT; i++) begin
            send_item(DIR_VALS[i], DIR_LAST[i]);
        end
        drain_results();

        // Random sets: mostly short, some medium, a few near, at or past the store
        // size. Force one exactly full set and one that overflows the store.
        stored  = 0;
        set_idx = 0;
        while (stored < STORED_TARGET) begin
            if (set_idx == 2) begin
                set_size = MAX_ELEMENTS;
            end else if (set_idx == 5) begin
                set_size = MAX_ELEMENTS + 2;
            end else begin
                case ($urandom_range(0, 24))
                    0, 1:    set_size = $urandom_range(MAX_ELEMENTS - 4, MAX_ELEMENTS + 6);
                    2, 3, 4: set_size = $urandom_range(10, 40);
                    default: set_size = $urandom_range(1, 9);
                endcase
            end
            mix      = t_val_mix'($urandom_range(0, 2));
            tx_quiet = ($urandom_range(0, 4) == 0);
            for (i = 0; i < set_size; i++) begin
                send_item(draw_value(mix), i == set_size - 1);
            end
            // count only elements that the store keeps
            stored += (set_size < MAX_ELEMENTS) ? set_size : MAX_ELEMENTS;
            set_idx++;
            if (set_idx % 6 == 0) begin
                drain_results();
            end
        end

        // wait out the outstanding results, then watch for strays
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hard stop if the run hangs
    initial begin
        #(12 * LIMIT_CYCLES);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bse_pkg.sv
rtl/bse_ram.sv
rtl/bse_datapath.sv
rtl/bse_ctrl.sv
rtl/bitonic_sort_engine.sv
tb/bse_sort_checker.sv
tb/testbench.sv
